[rtl/ht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap triangulator package
// Shared transaction types, state encodings and constants.
// ----------------------------------------------------------------------------
package ht_pkg;

    localparam int HEIGHT_W = 16;
    localparam int CFG_W    = 11;
    localparam int DIFF_W   = 17;
    localparam int QUOT_W   = 15;

    localparam logic [CFG_W-1:0]    GRID_W_RESET = 11'd256;
    localparam logic [15:0]         ROW_MAX      = 16'hFFFF;
    localparam logic [QUOT_W-1:0]   NORM_ONE     = 15'd16384;

    // vertex order within one cell
    localparam logic [2:0] V_T1_TL = 3'd0;
    localparam logic [2:0] V_T1_BL = 3'd1;
    localparam logic [2:0] V_T1_TR = 3'd2;
    localparam logic [2:0] V_T2_TR = 3'd3;
    localparam logic [2:0] V_T2_BL = 3'd4;
    localparam logic [2:0] V_T2_BR = 3'd5;

    typedef struct packed {
        logic [15:0] sample_height;
        logic        first_sample;
    } in_t;

    typedef struct packed {
        logic [9:0]         vert_x;
        logic [15:0]        vert_height;
        logic [15:0]        vert_z;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               last_vertex;
    } out_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_WR_A,
        ST_WR_B,
        ST_NORM,
        ST_EMIT
    } ht_state_t;

    typedef enum logic [2:0] {
        NU_IDLE,
        NU_SQ,
        NU_SUM,
        NU_ROOT,
        NU_DPREP,
        NU_DIV,
        NU_DONE
    } nu_state_t;

endpackage
`default_nettype wire

[rtl/ht_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/ht_normal.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Face normal unit
// Normalizes (dx, 65536, dz) to Q1.14: squares, bit-serial square root,
// then three restoring dividers running side by side.
// ----------------------------------------------------------------------------
module ht_normal (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [ht_pkg::DIFF_W-1:0]  diff_x,
    input  logic signed [ht_pkg::DIFF_W-1:0]  diff_z,
    output logic                              done,
    output logic signed [15:0]                norm_x,
    output logic signed [15:0]                norm_y,
    output logic signed [15:0]                norm_z
);
    import ht_pkg::*;

    localparam logic [33:0] BIT_INIT = 34'h1_0000_0000;
    localparam logic [33:0] NY_SQ    = 34'h1_0000_0000;
    localparam logic [16:0] NY_MAG   = 17'h10000;

    nu_state_t state_reg, state_next;

    logic signed [DIFF_W-1:0] nx_reg, nz_reg;
    logic [32:0]              sqx_reg, sqz_reg;
    logic [33:0]              v_reg, res_reg, bit_reg;
    logic [16:0]              rem_reg [3];
    logic [QUOT_W-1:0]        low_reg [3];
    logic [QUOT_W-1:0]        q_reg   [3];
    logic [3:0]               cnt_reg;

    logic signed [2*DIFF_W-1:0] prod_x, prod_z;
    logic [33:0]                trial_sum;
    logic                       root_ge;
    logic [16:0]                root;
    logic [16:0]                mag     [3];
    logic [30:0]                num     [3];
    logic [17:0]                trial   [3];
    logic                       neg     [3];
    logic signed [15:0]         signed_q [3];

    assign prod_x    = nx_reg * nx_reg;
    assign prod_z    = nz_reg * nz_reg;
    assign trial_sum = res_reg + bit_reg;
    assign root_ge   = (v_reg >= trial_sum);
    assign root      = res_reg[16:0];

    always_comb
    begin
        mag[0] = nx_reg[DIFF_W-1] ? 17'(-nx_reg) : 17'(nx_reg);
        mag[1] = NY_MAG;
        mag[2] = nz_reg[DIFF_W-1] ? 17'(-nz_reg) : 17'(nz_reg);
        neg[0] = nx_reg[DIFF_W-1];
        neg[1] = 1'b0;
        neg[2] = nz_reg[DIFF_W-1];
        for (int i = 0; i < 3; i++)
        begin
            num[i]      = {mag[i], 14'b0} + 31'(root >> 1);
            trial[i]    = {rem_reg[i], low_reg[i][QUOT_W-1]};
            signed_q[i] = neg[i] ? -$signed({1'b0, q_reg[i]}) : $signed({1'b0, q_reg[i]});
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            NU_IDLE:  if (start) state_next = NU_SQ;
            NU_SQ:    state_next = NU_SUM;
            NU_SUM:   state_next = NU_ROOT;
            NU_ROOT:  if (bit_reg[0]) state_next = NU_DPREP;
            NU_DPREP: state_next = NU_DIV;
            NU_DIV:   if (cnt_reg == 4'd0) state_next = NU_DONE;
            NU_DONE:  if (start) state_next = NU_SQ;
            default:  state_next = NU_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        done   = (state_reg == NU_DONE);
        norm_x = signed_q[0];
        norm_y = signed_q[1];
        norm_z = signed_q[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= NU_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            NU_IDLE, NU_DONE:
            begin
                if (start)
                begin
                    nx_reg <= diff_x;
                    nz_reg <= diff_z;
                end
            end
            NU_SQ:
            begin
                sqx_reg <= prod_x[32:0];
                sqz_reg <= prod_z[32:0];
            end
            NU_SUM:
            begin
                v_reg   <= {1'b0, sqx_reg} + {1'b0, sqz_reg} + NY_SQ;
                res_reg <= '0;
                bit_reg <= BIT_INIT;
            end
            NU_ROOT:
            begin
                if (root_ge)
                begin
                    v_reg   <= v_reg - trial_sum;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
            NU_DPREP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[i] <= {1'b0, num[i][30:15]};
                    low_reg[i] <= num[i][14:0];
                end
                cnt_reg <= 4'(QUOT_W - 1);
            end
            NU_DIV:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (trial[i] >= {1'b0, root})
                    begin
                        rem_reg[i] <= 17'(trial[i] - {1'b0, root});
                        q_reg[i]   <= {q_reg[i][QUOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[i] <= trial[i][16:0];
                        q_reg[i]   <= {q_reg[i][QUOT_W-2:0], 1'b0};
                    end
                    low_reg[i] <= low_reg[i] << 1;
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
            default:
            begin
            end
        endcase
    end

    a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == NU_ROOT |-> $onehot(bit_reg))
        else $error("square root bit lost");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == NU_DIV |-> rem_reg[0] < root && rem_reg[1] < root && rem_reg[2] < root)
        else $error("divider remainder out of range");

    a_unit_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == NU_DONE |-> q_reg[0] <= NORM_ONE && q_reg[1] <= NORM_ONE
                                 && q_reg[2] <= NORM_ONE)
        else $error("normal component above one");

endmodule
`default_nettype wire

[rtl/heightmap_triangulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Heightmap triangulator
// Turns a row-major stream of height samples into grid-cell triangles with
// per-face unit normals, six vertices per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one height sample per
//   transaction; first_sample restarts the column and row counters.
//   Output channel out_valid/out_stall/out_data carries one vertex per
//   transaction; last_vertex marks the sixth vertex of a cell. The user
//   writes grid_width with cfg_we/cfg_data only while idle (not enforced).
// Sequence:
//   A sample in column 0 is only registered; one in row 0 also passes the
//   line store reads and writes (ST_RD_A, ST_RD_B, ST_WR_A, ST_WR_B).
//   A sample that completes a cell passes the line store reads and writes,
//   then the normal units (17-step square root, 15-step dividers, both
//   triangles in parallel), then 6 vertices. One sample is in flight at a
//   time; in_stall stays high until the last vertex of the cell has gone
//   out.
// Reset:
//   After reset the line store is swept to zero with in_stall high.
//   A stalled vertex holds until out_stall drops.
// ----------------------------------------------------------------------------
module heightmap_triangulator #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [ht_pkg::CFG_W-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  ht_pkg::in_t               in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output ht_pkg::out_t              out_data
);
    import ht_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam logic [WW-1:0] MAX_W     = WW'(MAX_WIDTH);
    localparam logic [WW-1:0] MIN_W     = WW'(2);
    localparam logic [CW-1:0] LAST_ADDR = CW'(MAX_WIDTH - 1);

    ht_state_t state_reg, state_next;

    logic [CFG_W-1:0]    grid_width_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [15:0]         row_reg, row_next;
    logic [HEIGHT_W-1:0] left_reg;
    logic [CW-1:0]       clr_reg;
    logic [CW-1:0]       x_reg;
    logic [15:0]         y_reg;
    logic                last_col_reg;
    logic [HEIGHT_W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic [2:0]          emit_cnt_reg;

    logic [WW-1:0]       gw, w_eff, x_ext, x1_ext;
    logic [15:0]         row_pre;
    logic                accept;
    logic                out_fire;

    logic                ram_we;
    logic [CW-1:0]       ram_waddr, ram_raddr;
    logic [HEIGHT_W-1:0] ram_wdata, ram_rdata;

    logic                nu_start;
    logic                nu1_done, nu2_done;
    logic signed [15:0]  n1x, n1y, n1z, n2x, n2y, n2z;
    logic [9:0]          vx_hi, vx_lo;
    logic [15:0]         vz_top;

    assign accept   = in_valid && !in_stall;
    assign out_fire = out_valid && !out_stall;

    // clamp width and step the counters for the incoming sample
    always_comb
    begin
        gw = WW'(grid_width_reg);
        if (gw < MIN_W)
            w_eff = MIN_W;
        else if (gw > MAX_W)
            w_eff = MAX_W;
        else
            w_eff = gw;

        row_pre = row_reg;
        if (in_data.first_sample)
        begin
            x_ext   = '0;
            row_pre = '0;
        end
        else if (WW'(col_reg) >= w_eff)
        begin
            x_ext   = '0;
            row_pre = (row_reg != ROW_MAX) ? row_reg + 16'd1 : row_reg;
        end
        else
        begin
            x_ext = WW'(col_reg);
        end

        x1_ext = x_ext + WW'(1);
        if (x1_ext >= w_eff)
        begin
            col_next = '0;
            row_next = (row_pre != ROW_MAX) ? row_pre + 16'd1 : row_pre;
        end
        else
        begin
            col_next = x1_ext[CW-1:0];
            row_next = row_pre;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:  if (accept && x_ext != '0) state_next = ST_RD_A;
            ST_RD_A:  state_next = ST_RD_B;
            ST_RD_B:  state_next = ST_WR_A;
            ST_WR_A:  state_next = ST_WR_B;
            ST_WR_B:  state_next = (y_reg != 16'd0) ? ST_NORM : ST_IDLE;
            ST_NORM:  if (nu1_done && nu2_done) state_next = ST_EMIT;
            ST_EMIT:  if (out_fire && emit_cnt_reg == V_T2_BR) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = (state_reg != ST_IDLE);
        out_valid = (state_reg == ST_EMIT);
        nu_start  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = x_reg;
        ram_wdata = d_reg;
        ram_raddr = x_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_RD_A:
            begin
                ram_raddr = x_reg - CW'(1);
            end
            ST_WR_A:
            begin
                ram_we    = 1'b1;
                ram_waddr = x_reg - CW'(1);
                ram_wdata = c_reg;
            end
            ST_WR_B:
            begin
                ram_we   = last_col_reg;
                nu_start = (y_reg != 16'd0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            grid_width_reg <= GRID_W_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            left_reg       <= '0;
            clr_reg        <= '0;
            emit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                grid_width_reg <= cfg_data;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + CW'(1);
            if (accept)
            begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                left_reg     <= in_data.sample_height;
                emit_cnt_reg <= V_T1_TL;
            end
            if (out_fire)
                emit_cnt_reg <= emit_cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg        <= x_ext[CW-1:0];
            y_reg        <= row_pre;
            d_reg        <= in_data.sample_height;
            c_reg        <= left_reg;
            last_col_reg <= (x1_ext == w_eff);
        end
        if (state_reg == ST_RD_B)
            a_reg <= ram_rdata;
        if (state_reg == ST_WR_A)
            b_reg <= ram_rdata;
    end

    ht_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ht_normal u_norm1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (nu_start),
        .diff_x ($signed({1'b0, a_reg}) - $signed({1'b0, b_reg})),
        .diff_z ($signed({1'b0, a_reg}) - $signed({1'b0, c_reg})),
        .done   (nu1_done),
        .norm_x (n1x),
        .norm_y (n1y),
        .norm_z (n1z)
    );

    ht_normal u_norm2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (nu_start),
        .diff_x ($signed({1'b0, c_reg}) - $signed({1'b0, d_reg})),
        .diff_z ($signed({1'b0, b_reg}) - $signed({1'b0, d_reg})),
        .done   (nu2_done),
        .norm_x (n2x),
        .norm_y (n2y),
        .norm_z (n2z)
    );

    // vertex select
    always_comb
    begin
        logic [WW-1:0] xw;
        xw     = WW'(x_reg);
        vx_hi  = xw[9:0];
        vx_lo  = 10'(xw - WW'(1));
        vz_top = y_reg - 16'd1;
        out_data = '0;
        case (emit_cnt_reg)
            V_T1_TL: out_data = '{vx_lo, a_reg, vz_top, n1x, n1y, n1z, 1'b0};
            V_T1_BL: out_data = '{vx_lo, c_reg, y_reg,  n1x, n1y, n1z, 1'b0};
            V_T1_TR: out_data = '{vx_hi, b_reg, vz_top, n1x, n1y, n1z, 1'b0};
            V_T2_TR: out_data = '{vx_hi, b_reg, vz_top, n2x, n2y, n2z, 1'b0};
            V_T2_BL: out_data = '{vx_lo, c_reg, y_reg,  n2x, n2y, n2z, 1'b0};
            V_T2_BR: out_data = '{vx_hi, d_reg, y_reg,  n2x, n2y, n2z, 1'b1};
            default: out_data = '0;
        endcase
    end

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("input taken while vertices pending");

    a_cell_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && emit_cnt_reg == V_T2_BR |=> state_reg == ST_IDLE)
        else $error("cell did not end after sixth vertex");

    a_normal_up: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.normal_y > 16'sd0)
        else $error("normal y not positive");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_data.first_sample |=> row_reg == 16'd0 && col_reg == CW'(1))
        else $error("first sample did not restart counters");

endmodule
`default_nettype wire
